/* rtl/mss_pkg.sv */
// shared types, opcode and function codes for the instruction step block
package mss_pkg;

   localparam int MemWords = 1024;
   localparam int MemAw    = $clog2(MemWords);
   localparam int RegAw    = 5;

   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LUI     = 6'h0F;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_SW      = 6'h2B;

   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_SRA  = 6'h03;
   localparam logic [5:0] FN_SLLV = 6'h04;
   localparam logic [5:0] FN_SRLV = 6'h06;
   localparam logic [5:0] FN_SRAV = 6'h07;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_MFHI = 6'h10;
   localparam logic [5:0] FN_MFLO = 6'h12;
   localparam logic [5:0] FN_MULT = 6'h18;
   localparam logic [5:0] FN_DIV  = 6'h1A;
   localparam logic [5:0] FN_ADD  = 6'h20;
   localparam logic [5:0] FN_SUB  = 6'h22;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_XOR  = 6'h26;
   localparam logic [5:0] FN_SLT  = 6'h2A;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_MEM, ST_MUL, ST_DIV, ST_DIVFIX, ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_en;
      logic capture;
      logic exec;
      logic load_fin;
      logic mul_start;
      logic mul_step;
      logic div_start;
      logic div_step;
      logic arith_fin;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_load;
      logic is_mult;
      logic is_div;
      logic clear_last;
      logic step_last;
   } stat_type;

endpackage

/* rtl/mss_ram.sv */
// generic single-port ram with registered read
module mss_ram #(
   parameter int Width = 32,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data_ff <= mem[addr];
   end
   assign rd_data = rd_data_ff;
endmodule

/* rtl/mss_ctrl.sv */
// sequencing state machine for the instruction step
module mss_ctrl
   import mss_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   input  stat_type stat,
   output cmd_type  cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            if (stat.is_mult) begin
               cmd.mul_start = 1'b1;
               state_in = ST_MUL;
            end else if (stat.is_div) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.exec = 1'b1;
               state_in = stat.is_load ? ST_MEM : ST_DONE;
            end
         end
         ST_MEM: begin
            cmd.load_fin = 1'b1;
            state_in = ST_DONE;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (stat.step_last) state_in = ST_DIVFIX;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.step_last) state_in = ST_DIVFIX;
         end
         ST_DIVFIX: begin
            cmd.arith_fin = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.commit = 1'b1;
               req_stall = 1'b0;
               if (req_valid) begin
                  cmd.capture = 1'b1;
                  state_in = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

/* rtl/mss_dp.sv */
// datapath: decode, register file, alu, iterative mult/div, data memory
module mss_dp
   import mss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic [31:0] req_instr_word,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_hilo_written,
   output logic [31:0] rsp_hi_value,
   output logic [31:0] rsp_lo_value,
   output logic        rsp_store_done,
   output logic [31:0] rsp_store_address,
   output logic [31:0] rsp_store_data,
   output logic        rsp_fault
);
   logic [31:0] ir_ff, pc_ff, hi_ff, lo_ff;
   logic [31:0] regs_ff [32];
   logic [31:0] a_ff, b_ff;
   logic [MemAw-1:0] clr_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] acc_ff;
   logic [31:0] dvs_ff;
   logic        sa_ff, sq_ff, dz_ff;

   logic [31:0] npc_ff, wval_ff, nhi_ff, nlo_ff, saddr_ff, sdata_ff;
   logic [4:0]  widx_ff;
   logic        wr_ff, hl_ff, st_ff, bad_ff;

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sh;
   logic [31:0] sx, ea;
   logic        is_mult, is_div;
   logic [31:0] mem_rd;
   logic        mem_we;
   logic [MemAw-1:0] mem_addr;

   assign op = ir_ff[31:26];
   assign rs = ir_ff[25:21];
   assign rt = ir_ff[20:16];
   assign rd = ir_ff[15:11];
   assign sh = ir_ff[10:6];
   assign fn = ir_ff[5:0];
   assign sx = {{16{ir_ff[15]}}, ir_ff[15:0]};
   assign ea = a_ff + sx;
   assign is_mult = (op == OP_SPECIAL) && (fn == FN_MULT);
   assign is_div  = (op == OP_SPECIAL) && (fn == FN_DIV);

   assign stat.is_load    = (op == OP_LW);
   assign stat.is_mult    = is_mult;
   assign stat.is_div     = is_div;
   assign stat.clear_last = (clr_ff == MemAw'(MemWords - 1));
   assign stat.step_last  = (cnt_ff == 6'd31);

   assign mem_we   = cmd.clear_en || (cmd.commit && st_ff);
   assign mem_addr = cmd.clear_en ? clr_ff :
                     cmd.commit ? saddr_ff[MemAw+1:2] : ea[MemAw+1:2];

   mss_ram #(.Width(32), .Depth(MemWords)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .addr    (mem_addr),
      .wr_data (cmd.clear_en ? 32'd0 : sdata_ff),
      .rd_data (mem_rd)
   );

   // combinational decode and execute of everything except mult/div
   logic [31:0] e_npc, e_val, pc4;
   logic [4:0]  e_idx;
   logic        e_wr, e_st, e_bad;
   always_comb begin
      pc4   = pc_ff + 32'd4;
      e_npc = pc4;
      e_val = '0;
      e_idx = rt;
      e_wr  = 1'b1;
      e_st  = 1'b0;
      e_bad = 1'b0;
      if (op == OP_SPECIAL) begin
         e_idx = rd;
         case (fn)
            FN_ADD:  e_val = a_ff + b_ff;
            FN_SUB:  e_val = a_ff - b_ff;
            FN_AND:  e_val = a_ff & b_ff;
            FN_OR:   e_val = a_ff | b_ff;
            FN_XOR:  e_val = a_ff ^ b_ff;
            FN_SLT:  e_val = {31'd0, $signed(a_ff) < $signed(b_ff)};
            FN_SLL:  begin e_bad = rs != 5'd0; e_val = b_ff << sh; end
            FN_SRL:  begin e_bad = rs != 5'd0; e_val = b_ff >> sh; end
            FN_SRA:  begin e_bad = rs != 5'd0; e_val = $signed(b_ff) >>> sh; end
            FN_SLLV: e_val = b_ff << a_ff[4:0];
            FN_SRLV: e_val = b_ff >> a_ff[4:0];
            FN_SRAV: e_val = $signed(b_ff) >>> a_ff[4:0];
            FN_MFHI: begin e_bad = (rs | rt) != 5'd0; e_val = hi_ff; end
            FN_MFLO: begin e_bad = (rs | rt) != 5'd0; e_val = lo_ff; end
            FN_JR:   begin e_bad = (rt | rd) != 5'd0; e_wr = 1'b0; e_npc = a_ff; end
            default: e_bad = 1'b1;
         endcase
      end else if (op == OP_J || op == OP_JAL) begin
         // target is the 26-bit index times four, upper pc bits not merged
         e_npc = {4'd0, ir_ff[25:0], 2'b00};
         e_wr  = (op == OP_JAL);
         e_idx = 5'd31;
         e_val = pc4;
      end else begin
         case (op)
            OP_ADDI: e_val = ea;
            OP_SLTI: e_val = {31'd0, $signed(a_ff) < $signed(sx)};
            OP_ANDI: e_val = a_ff & {16'd0, ir_ff[15:0]};
            OP_ORI:  e_val = a_ff | {16'd0, ir_ff[15:0]};
            OP_XORI: e_val = a_ff ^ {16'd0, ir_ff[15:0]};
            OP_LUI:  begin e_bad = rs != 5'd0; e_val = {ir_ff[15:0], 16'd0}; end
            OP_LW:   e_val = '0;
            OP_SW:   begin e_wr = 1'b0; e_st = 1'b1; end
            OP_BEQ, OP_BNE: begin
               e_wr = 1'b0;
               if ((a_ff == b_ff) == (op == OP_BEQ)) e_npc = pc4 + {sx[29:0], 2'b00};
            end
            default: e_bad = 1'b1;
         endcase
      end
      if (e_idx == 5'd0) e_wr = 1'b0;
      if (e_bad) begin
         e_wr = 1'b0; e_st = 1'b0; e_npc = pc_ff;
      end
   end

   // shift-add multiply and restoring divide on magnitudes
   logic [31:0] ma, mb;
   logic [32:0] psum, trial;
   logic [63:0] shl;
   logic [63:0] mres;
   always_comb begin
      ma    = a_ff[31] ? 32'd0 - a_ff : a_ff;
      mb    = b_ff[31] ? 32'd0 - b_ff : b_ff;
      psum  = {1'b0, acc_ff[63:32]} + (acc_ff[0] ? {1'b0, dvs_ff} : 33'd0);
      shl   = {acc_ff[62:0], 1'b0};
      trial = {1'b0, shl[63:32]} - {1'b0, dvs_ff};
      mres  = sq_ff ? 64'd0 - acc_ff : acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         hi_ff  <= '0;
         lo_ff  <= '0;
         clr_ff <= '0;
         for (int i = 0; i < 32; i++) regs_ff[i] <= '0;
      end else begin
         if (cmd.clear_en) clr_ff <= clr_ff + 1'b1;
         if (cmd.commit) begin
            pc_ff <= npc_ff;
            if (wr_ff) regs_ff[widx_ff] <= wval_ff;
            if (hl_ff) begin hi_ff <= nhi_ff; lo_ff <= nlo_ff; end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) ir_ff <= req_instr_word;
      if (cmd.capture || cmd.mul_start || cmd.div_start) cnt_ff <= '0;
      else if (cmd.mul_step || cmd.div_step) cnt_ff <= cnt_ff + 1'b1;
      a_ff <= regs_ff[rs];
      b_ff <= regs_ff[rt];
      if (cmd.exec) begin
         npc_ff   <= e_npc;
         wr_ff    <= e_wr;
         widx_ff  <= e_wr ? e_idx : 5'd0;
         wval_ff  <= e_wr ? e_val : 32'd0;
         hl_ff    <= 1'b0;
         nhi_ff   <= '0;
         nlo_ff   <= '0;
         st_ff    <= e_st;
         saddr_ff <= e_st ? ea : 32'd0;
         sdata_ff <= e_st ? b_ff : 32'd0;
         bad_ff   <= e_bad;
      end
      if (cmd.load_fin && wr_ff) wval_ff <= mem_rd;
      if (cmd.mul_start || cmd.div_start) begin
         // both mult and div leave registers and memory untouched; pc advances unless they fault
         wr_ff <= 1'b0; widx_ff <= '0; wval_ff <= '0;
         st_ff <= 1'b0; saddr_ff <= '0; sdata_ff <= '0;
         bad_ff <= (rd != 5'd0);
         hl_ff  <= (rd == 5'd0);
         npc_ff <= (rd != 5'd0) ? pc_ff : pc_ff + 32'd4;
         acc_ff <= {32'd0, ma};
         dvs_ff <= mb;
         sa_ff  <= a_ff[31];
         sq_ff  <= a_ff[31] ^ b_ff[31];
         dz_ff  <= (b_ff == 32'd0);
      end
      if (cmd.mul_step) acc_ff <= {psum, acc_ff[31:1]};
      if (cmd.div_step) begin
         if (!trial[32]) acc_ff <= {trial[31:0], shl[31:1], 1'b1};
         else acc_ff <= shl;
      end
      if (cmd.arith_fin) begin
         if (!hl_ff) begin
            nhi_ff <= '0; nlo_ff <= '0;
         end else if (is_mult) begin
            nhi_ff <= mres[63:32]; nlo_ff <= mres[31:0];
         end else if (dz_ff) begin
            nhi_ff <= a_ff; nlo_ff <= 32'hFFFF_FFFF;
         end else begin
            nlo_ff <= sq_ff ? 32'd0 - acc_ff[31:0] : acc_ff[31:0];
            nhi_ff <= sa_ff ? 32'd0 - acc_ff[63:32] : acc_ff[63:32];
         end
      end
   end

   assign rsp_next_pc       = npc_ff;
   assign rsp_reg_written   = wr_ff;
   assign rsp_reg_index     = widx_ff;
   assign rsp_reg_value     = wval_ff;
   assign rsp_hilo_written  = hl_ff;
   assign rsp_hi_value      = nhi_ff;
   assign rsp_lo_value      = nlo_ff;
   assign rsp_store_done    = st_ff;
   assign rsp_store_address = saddr_ff;
   assign rsp_store_data    = sdata_ff;
   assign rsp_fault         = bad_ff;
endmodule

/* rtl/mips_subset_instruction_step.sv */
// top level: one mips-i subset instruction executed per beat
// alu, branch and jump need read and execute; lw adds a memory read; mult and div add steps
// throughput: next beat accepted in the cycle its result beat is taken
// the iterative mult/div unit (one bit a cycle, 32 steps) sets the worst case
// reset: pc, registers, hi and lo clear at once; data memory is swept to zero
// word by word after reset, during which no request beat is taken
module mips_subset_instruction_step
   import mss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_instr_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_reg_index,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_hilo_written,
   output logic [31:0] rsp_hi_value,
   output logic [31:0] rsp_lo_value,
   output logic        rsp_store_done,
   output logic [31:0] rsp_store_address,
   output logic [31:0] rsp_store_data,
   output logic        rsp_fault
);
   cmd_type  cmd;
   stat_type stat;

   // controller sequences memory clear, read, execute, multi-cycle arithmetic and commit
   mss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath holds architectural state; it commits when the result beat leaves
   mss_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_instr_word    (req_instr_word),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_reg_written   (rsp_reg_written),
      .rsp_reg_index     (rsp_reg_index),
      .rsp_reg_value     (rsp_reg_value),
      .rsp_hilo_written  (rsp_hilo_written),
      .rsp_hi_value      (rsp_hi_value),
      .rsp_lo_value      (rsp_lo_value),
      .rsp_store_done    (rsp_store_done),
      .rsp_store_address (rsp_store_address),
      .rsp_store_data    (rsp_store_data),
      .rsp_fault         (rsp_fault)
   );

`ifndef NO_ASSERTIONS
   // a fault beat reports no side effect
   a_fault_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> !rsp_reg_written && !rsp_hilo_written && !rsp_store_done)
      else $error("fault beat carries a write");
   // at most one kind of write per instruction
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_reg_written, rsp_hilo_written, rsp_store_done}))
      else $error("more than one write kind");
   // register zero is never reported written
   a_no_r0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reg_written |-> rsp_reg_index != 5'd0)
      else $error("write to register zero");
   // no request is taken while a result beat waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while result stalled");
`endif
endmodule
